### hdl/kvlt_pkg.sv
// Package for the key/value line tokenizer: parse phases, character codes, field widths.
`default_nettype none
package kvlt_pkg;

    typedef enum logic [2:0] {
        PH_WS,
        PH_SLASH,
        PH_COMMENT,
        PH_QKEY,
        PH_UKEY,
        PH_SEP,
        PH_QVAL,
        PH_UVAL
    } kvlt_phase_t;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_EQUALS = 8'h3D;

    localparam int FIELD_W  = 22;
    localparam int INDEX_W  = 12;
    localparam int IN_W     = 8;
    localparam int OUT_W    = 104;

endpackage
`default_nettype wire

### hdl/key_value_line_tokenizer.sv
// Key/value line tokenizer: byte-serial parser with a registered entry output.
//
// Takes one text byte per cycle on the s_ stream (s_tlast marks the final byte of a
// buffer, a zero byte also ends it) and returns one word per key/value pair found, in the
// cycle after the byte that completes the pair. Throughput is one byte per cycle; the
// input stalls only while a finished entry sits in the output register and m_tready is
// low. The parse state and all offset counters update once for each accepted byte.
`default_nettype none
module key_value_line_tokenizer
    import kvlt_pkg::*;
#(
    parameter int MAX_ENTRIES = 4096,
    parameter int OFFSET_BITS = 22
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [IN_W-1:0]   s_tdata,   // text_byte[7:0]
    input  wire logic              s_tlast,   // buffer_last
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    // key_offset[21:0], key_length[43:22], value_offset[65:44], value_length[87:66],
    // entry_index[99:88], table_full[100], zero fill[103:101]
    output logic [OUT_W-1:0]       m_tdata
);

    localparam int OB  = OFFSET_BITS;
    localparam int ESW = $clog2(MAX_ENTRIES + 1);

    kvlt_phase_t     phase_reg, phase_next;
    logic [OB-1:0]   pos_reg, pos_next;
    logic [OB-1:0]   kb_reg, kb_next;
    logic [OB-1:0]   kc_reg, kc_next;
    logic            kfp_reg, kfp_next;
    logic [OB-1:0]   vb_reg, vb_next;
    logic [ESW-1:0]  es_reg, es_next;
    logic            m_tvalid_reg;
    logic [OUT_W-1:0] m_tdata_reg;

    logic            accept;
    logic [7:0]      b;
    logic            buf_end, full;
    logic            do_bare_key, do_bare_val;
    logic            try_take, try_end, emit;
    logic [OB-1:0]   endpos, vlen;
    logic            is_ws, is_crlf;
    logic [31:0]     ko32, kl32, vo32, vl32, ei32;
    logic            tfull;

    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign b        = s_tdata;
    assign buf_end  = (b == CH_NUL) || s_tlast;
    assign full     = es_reg >= ESW'(MAX_ENTRIES);
    assign is_crlf  = (b == CH_CR) || (b == CH_LF);
    assign is_ws    = (b == CH_SPACE) || (b == CH_TAB) || is_crlf;

    always_comb begin
        phase_next  = phase_reg;
        pos_next    = pos_reg;
        kb_next     = kb_reg;
        kc_next     = kc_reg;
        kfp_next    = kfp_reg;
        vb_next     = vb_reg;
        es_next     = es_reg;
        do_bare_key = 1'b0;
        do_bare_val = 1'b0;
        try_take    = 1'b0;
        try_end     = 1'b0;

        if (!full && b != CH_NUL) begin
            unique case (phase_reg)
                PH_WS: begin
                    if (!is_ws) begin
                        if (b == CH_SLASH) begin
                            phase_next = PH_SLASH;
                        end else if (b == CH_QUOTE) begin
                            kb_next    = pos_reg + OB'(1);
                            kfp_next   = 1'b1;
                            phase_next = PH_QKEY;
                        end else begin
                            kb_next     = pos_reg;
                            kfp_next    = 1'b1;
                            phase_next  = PH_UKEY;
                            do_bare_key = 1'b1;
                        end
                    end
                end
                PH_SLASH: begin
                    if (b == CH_SLASH) begin
                        phase_next = PH_COMMENT;
                    end else begin
                        // lone slash: bare key starting at the slash
                        kb_next     = pos_reg - OB'(1);
                        kfp_next    = 1'b0;
                        phase_next  = PH_UKEY;
                        do_bare_key = 1'b1;
                    end
                end
                PH_COMMENT: begin
                    if (b == CH_LF) phase_next = PH_WS;
                end
                PH_QKEY: begin
                    if (b == CH_QUOTE) begin
                        kc_next    = pos_reg - kb_reg;
                        phase_next = PH_SEP;
                    end else begin
                        if (kfp_reg && b == CH_DOLLAR) kb_next = pos_reg + OB'(1);
                        kfp_next = 1'b0;
                    end
                end
                PH_UKEY: do_bare_key = 1'b1;
                PH_SEP: begin
                    if (b == CH_QUOTE) begin
                        vb_next    = pos_reg + OB'(1);
                        phase_next = PH_QVAL;
                    end else if (!(b == CH_SPACE || b == CH_TAB || b == CH_EQUALS)) begin
                        vb_next     = pos_reg;
                        phase_next  = PH_UVAL;
                        do_bare_val = 1'b1;
                    end
                end
                PH_QVAL: begin
                    if (b == CH_QUOTE) begin
                        phase_next = PH_WS;
                        try_take   = 1'b1;
                    end
                end
                PH_UVAL: do_bare_val = 1'b1;
            endcase

            if (do_bare_key) begin
                if (is_ws || b == CH_EQUALS) begin
                    kc_next    = pos_reg - kb_next;
                    phase_next = PH_SEP;
                end else begin
                    if (kfp_next && b == CH_DOLLAR) kb_next = pos_reg + OB'(1);
                    kfp_next = 1'b0;
                end
            end
            if (do_bare_val && is_crlf) begin
                phase_next = PH_WS;
                try_take   = 1'b1;
            end
            pos_next = pos_reg + OB'(1);
        end

        // end of buffer commits an open value at the end position
        if (buf_end && !full && (phase_next == PH_QVAL || phase_next == PH_UVAL))
            try_end = 1'b1;

        endpos = try_end ? pos_next : pos_reg;
        vlen   = endpos - vb_next;
        emit   = (try_take || try_end) && (kc_next != '0) && (vlen != '0);
        if (emit) es_next = es_reg + ESW'(1);
        tfull  = es_next >= ESW'(MAX_ENTRIES);

        ko32 = 32'(kb_next);
        kl32 = 32'(kc_next);
        vo32 = 32'(vb_next);
        vl32 = 32'(vlen);
        ei32 = 32'(es_reg);

        if (buf_end) begin
            phase_next = PH_WS;
            pos_next   = '0;
            kb_next    = '0;
            kc_next    = '0;
            kfp_next   = 1'b0;
            vb_next    = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_WS;
            pos_reg      <= '0;
            kb_reg       <= '0;
            kc_reg       <= '0;
            kfp_reg      <= 1'b0;
            vb_reg       <= '0;
            es_reg       <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (accept) begin
                phase_reg <= phase_next;
                pos_reg   <= pos_next;
                kb_reg    <= kb_next;
                kc_reg    <= kc_next;
                kfp_reg   <= kfp_next;
                vb_reg    <= vb_next;
                es_reg    <= es_next;
            end
            if (accept && emit) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && emit) begin
            m_tdata_reg <= {3'b000, tfull, ei32[INDEX_W-1:0], vl32[FIELD_W-1:0],
                            vo32[FIELD_W-1:0], kl32[FIELD_W-1:0], ko32[FIELD_W-1:0]};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule
`default_nettype wire

### hdl/kvlt_checker.sv
// Port-level checker for the key/value line tokenizer, bound to the top level.
`default_nettype none
module kvlt_checker (
    input wire logic         aclk,
    input wire logic         aresetn,
    input wire logic         s_tvalid,
    input wire logic         s_tready,
    input wire logic [7:0]   s_tdata,
    input wire logic         s_tlast,
    input wire logic         m_tvalid,
    input wire logic         m_tready,
    input wire logic [103:0] m_tdata
);

    // output register empty after reset
    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("m_tvalid high after reset");

    // a held word stays put
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled word changed");

    // input stalls only while a word is waiting
    a_backpressure: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready == (!m_tvalid || m_tready))
        else $error("s_tready does not follow output register");

    // every entry has a non-empty key and value
    a_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[43:22] != 22'd0) && (m_tdata[87:66] != 22'd0))
        else $error("empty key or value emitted");

    // no word appears without an accepted byte
    a_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready))
        else $error("word emitted without input");

endmodule

bind key_value_line_tokenizer kvlt_checker u_kvlt_checker (.*);
`default_nettype wire
